[hdl/multi_voice_oscillator_mixer_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the oscillator mixer
// Shorthand for clocked assertions on clk with asynchronous reset arst_n.
// ----------------------------------------------------------------------------
`ifndef MULTI_VOICE_OSCILLATOR_MIXER_MACROS_SVH
`define MULTI_VOICE_OSCILLATOR_MIXER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define MVOM_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define MVOM_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define MVOM_ASSERT(label, prop, msg)
`define MVOM_NEVER(label, cond, msg)
`endif
`endif

[hdl/mvom_pkg.sv]
// ----------------------------------------------------------------------------
// mvom_pkg
// Widths, codes, control structs and the sine table of the oscillator mixer.
// ----------------------------------------------------------------------------
`default_nettype none

package mvom_pkg;

	localparam int NUM_VOICES   = 16;
	localparam int SINE_ENTRIES = 1024;

	localparam int VOICE_W       = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
	localparam int SINE_ADDR_W   = $clog2(SINE_ENTRIES);
	localparam int CMD_W         = 2;
	localparam int VOICE_FIELD_W = 4;
	localparam int WAVE_W        = 2;
	localparam int FREQ_W        = 15;
	localparam int GAIN_W        = 16;
	localparam int SAMPLE_W      = 22;
	localparam int PHASE_W       = 24;
	localparam int SINE_W        = 16;
	localparam int LEVEL_W       = 17;
	localparam int FRAC_W        = 15;
	localparam int SAW_SHIFT     = 9;
	localparam int SAW_W         = PHASE_W - SAW_SHIFT;

	localparam int DIGIT_W     = 4;
	localparam int GAIN_DIGITS = GAIN_W / DIGIT_W;
	localparam int DIGIT_CNT_W = (GAIN_DIGITS > 1) ? $clog2(GAIN_DIGITS) : 1;
	localparam int PROD_W      = LEVEL_W + DIGIT_W + 1;
	localparam int PART_W      = LEVEL_W + GAIN_W;
	localparam int VOICE_SUM_W = PART_W + $clog2(NUM_VOICES);
	localparam int ACC_W       = (VOICE_SUM_W > SAMPLE_W + FRAC_W) ?
		VOICE_SUM_W : SAMPLE_W + FRAC_W + 1;
	localparam int SHIFT_W     = ACC_W - FRAC_W;

	localparam int STEP_MUL_W  = 17;
	localparam int STEP_PROD_W = FREQ_W + STEP_MUL_W;
	localparam int STEP_SHIFT  = 8;
	localparam logic [FREQ_W-1:0]     FREQ_MAX = FREQ_W'(22050);
	localparam logic [STEP_MUL_W-1:0] STEP_MUL = STEP_MUL_W'(97392);

	localparam int SAMPLE_MAX = 2097151;
	localparam int SAMPLE_MIN = -2097152;

	localparam logic signed [LEVEL_W-1:0] LEVEL_FULL = LEVEL_W'(32768);

	localparam logic [CMD_W-1:0] CMD_TICK = 2'd0;
	localparam logic [CMD_W-1:0] CMD_SET  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_INIT = 2'd2;

	localparam logic [WAVE_W-1:0] WAVE_SINE   = 2'd0;
	localparam logic [WAVE_W-1:0] WAVE_SQUARE = 2'd1;
	localparam logic [WAVE_W-1:0] WAVE_SAW    = 2'd2;
	localparam logic [WAVE_W-1:0] WAVE_SILENT = 2'd3;

	typedef struct packed {
		logic                  set_en;
		logic                  init_en;
		logic                  advance;
		logic [VOICE_W-1:0]    sel;
		logic [WAVE_W-1:0]     wave;
		logic [FREQ_W-1:0]     freq;
		logic [GAIN_W-1:0]     gain;
	} bank_ctrl_t;

	typedef struct packed {
		logic [PHASE_W-1:0] phase;
		logic [WAVE_W-1:0]  wave;
		logic [GAIN_W-1:0]  gain;
	} voice_view_t;

	typedef struct packed {
		logic clear;
		logic load;
		logic shift;
		logic accum;
	} mac_ctrl_t;

	typedef logic [SINE_ENTRIES-1:0][SINE_W-1:0] sine_rom_t;

	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	// Quarter-wave odd Taylor series of degree nine in unsigned Q30,
	// rounded to Q15; the second half of the cycle is negated.
	function automatic sine_rom_t build_sine_rom();
		sine_rom_t         rom;
		logic [63:0]       m;
		logic [63:0]       x;
		logic [63:0]       x2;
		logic [63:0]       term;
		logic signed [63:0] sum;
		logic              neg;
		for (int i = 0; i < SINE_ENTRIES; i++) begin
			m = 64'(i) * 64'd4;
			neg = 1'b0;
			if (m >= 64'(2 * SINE_ENTRIES)) begin
				neg = 1'b1;
				m = m - 64'(2 * SINE_ENTRIES);
			end
			if (m > 64'(SINE_ENTRIES)) begin
				m = 64'(2 * SINE_ENTRIES) - m;
			end
			x = (HALF_PI_Q30 * m) / SINE_ENTRIES;
			x2 = (x * x) >> 30;
			sum = $signed(x);
			term = ((x * x2) >> 30) / 6;
			sum = sum - $signed(term);
			term = ((term * x2) >> 30) / 20;
			sum = sum + $signed(term);
			term = ((term * x2) >> 30) / 42;
			sum = sum - $signed(term);
			term = ((term * x2) >> 30) / 72;
			sum = sum + $signed(term);
			if (sum < 0) begin
				sum = 0;
			end
			sum = (sum + 64'sd16384) >>> 15;
			if (sum > 64'sd32767) begin
				sum = 64'sd32767;
			end
			rom[i] = neg ? SINE_W'(-sum) : SINE_W'(sum);
		end
		return rom;
	endfunction

	localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

`default_nettype wire

[hdl/mvom_sine_rom.sv]
// ----------------------------------------------------------------------------
// mvom_sine_rom
// Full-cycle Q1.15 sine table with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module mvom_sine_rom
	import mvom_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     en,
	input  wire logic [SINE_ADDR_W-1:0]   addr,
	output logic signed [SINE_W-1:0]      data
);

	logic [SINE_W-1:0] data_q;

	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= SINE_ROM[addr];
		end
	end

	assign data = $signed(data_q);

endmodule

`default_nettype wire

[hdl/mvom_voice_bank.sv]
// ----------------------------------------------------------------------------
// mvom_voice_bank
// Per-voice phase, step, gain and waveform registers with set, init and
// phase advance.
// ----------------------------------------------------------------------------
`default_nettype none

module mvom_voice_bank
	import mvom_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire bank_ctrl_t  ctrl,
	output voice_view_t      view
);

	logic [PHASE_W-1:0] phase_q [NUM_VOICES];
	logic [PHASE_W-1:0] step_q  [NUM_VOICES];
	logic [GAIN_W-1:0]  gain_q  [NUM_VOICES];
	logic [WAVE_W-1:0]  wave_q  [NUM_VOICES];

	logic [FREQ_W-1:0]      freq_clamped;
	logic [STEP_PROD_W-1:0] step_prod;
	logic [PHASE_W-1:0]     step_calc;
	logic [PHASE_W:0]       phase_sum;
	logic [PHASE_W-1:0]     phase_next;
	logic [WAVE_W-1:0]      wave_sel;

	assign freq_clamped = (ctrl.freq > FREQ_MAX) ? FREQ_MAX : ctrl.freq;
	assign step_prod    = STEP_PROD_W'(freq_clamped) * STEP_PROD_W'(STEP_MUL);
	assign step_calc    = step_prod[STEP_SHIFT +: PHASE_W];

	assign wave_sel  = wave_q[ctrl.sel];
	assign phase_sum = {1'b0, phase_q[ctrl.sel]} + {1'b0, step_q[ctrl.sel]};

	// Square and sawtooth restart at the cycle end; sine and silent wrap.
	always_comb begin
		case (wave_sel)
			WAVE_SQUARE, WAVE_SAW: begin
				phase_next = phase_sum[PHASE_W] ? '0 : phase_sum[PHASE_W-1:0];
			end
			default: begin
				phase_next = phase_sum[PHASE_W-1:0];
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_VOICES; i++) begin
				phase_q[i] <= '0;
				step_q[i]  <= '0;
				gain_q[i]  <= '0;
				wave_q[i]  <= '0;
			end
		end else if (ctrl.init_en) begin
			phase_q[ctrl.sel] <= '0;
			step_q[ctrl.sel]  <= '0;
			gain_q[ctrl.sel]  <= '0;
			wave_q[ctrl.sel]  <= ctrl.wave;
		end else if (ctrl.set_en) begin
			gain_q[ctrl.sel] <= ctrl.gain;
			wave_q[ctrl.sel] <= ctrl.wave;
			if (ctrl.wave != WAVE_SILENT) begin
				step_q[ctrl.sel] <= step_calc;
			end
		end else if (ctrl.advance && (gain_q[ctrl.sel] != '0)) begin
			phase_q[ctrl.sel] <= phase_next;
		end
	end

	assign view.phase = phase_next;
	assign view.wave  = wave_sel;
	assign view.gain  = gain_q[ctrl.sel];

endmodule

`default_nettype wire

[hdl/mvom_serial_mac.sv]
// ----------------------------------------------------------------------------
// mvom_serial_mac
// Digit-serial level times gain product, frame accumulator and saturation.
// The gain is shifted out four bits per cycle, most significant digit first.
// ----------------------------------------------------------------------------
`default_nettype none

module mvom_serial_mac
	import mvom_pkg::*;
(
	input  wire logic                        clk,
	input  wire mac_ctrl_t                   ctrl,
	input  wire voice_view_t                 view,
	input  wire logic signed [SINE_W-1:0]    sine_level,
	output logic signed [SAMPLE_W-1:0]       sample
);

	localparam logic signed [SHIFT_W-1:0] SAT_HI = SHIFT_W'(SAMPLE_MAX);
	localparam logic signed [SHIFT_W-1:0] SAT_LO = SHIFT_W'(SAMPLE_MIN);

	logic [WAVE_W-1:0]         wave_s1;
	logic [SAW_W-1:0]          phase_hi_s1;
	logic [GAIN_W-1:0]         gain_sr_q;
	logic signed [PART_W-1:0]  partial_q;
	logic signed [ACC_W-1:0]   acc_q;

	logic signed [LEVEL_W-1:0] level;
	logic [DIGIT_W-1:0]        digit;
	logic signed [PROD_W-1:0]  prod;
	logic signed [PART_W-1:0]  partial_next;
	logic signed [SHIFT_W-1:0] acc_shift;

	always_comb begin
		case (wave_s1)
			WAVE_SINE:   level = LEVEL_W'(sine_level);
			WAVE_SQUARE: level = phase_hi_s1[SAW_W-1] ? LEVEL_FULL : '0;
			WAVE_SAW:    level = $signed(LEVEL_W'(phase_hi_s1));
			default:     level = '0;
		endcase
	end

	assign digit        = gain_sr_q[GAIN_W-1 -: DIGIT_W];
	assign prod         = PROD_W'(level) * PROD_W'($signed({1'b0, digit}));
	assign partial_next = (partial_q <<< DIGIT_W) + PART_W'(prod);

	always_ff @(posedge clk) begin
		if (ctrl.clear) begin
			acc_q     <= '0;
			partial_q <= '0;
		end else begin
			if (ctrl.accum) begin
				acc_q <= acc_q + ACC_W'(partial_q);
			end
			if (ctrl.load) begin
				wave_s1     <= view.wave;
				phase_hi_s1 <= view.phase[PHASE_W-1:SAW_SHIFT];
				gain_sr_q   <= view.gain;
				partial_q   <= '0;
			end else if (ctrl.shift) begin
				gain_sr_q <= gain_sr_q << DIGIT_W;
				partial_q <= partial_next;
			end
		end
	end

	assign acc_shift = $signed(acc_q[ACC_W-1:FRAC_W]);

	always_comb begin
		if (acc_shift > SAT_HI) begin
			sample = SAMPLE_W'(SAMPLE_MAX);
		end else if (acc_shift < SAT_LO) begin
			sample = SAMPLE_W'(SAMPLE_MIN);
		end else begin
			sample = acc_shift[SAMPLE_W-1:0];
		end
	end

endmodule

`default_nettype wire

[hdl/multi_voice_oscillator_mixer.sv]
// ----------------------------------------------------------------------------
// multi_voice_oscillator_mixer
// Bank of sine, square and sawtooth oscillators mixed into one audio sample.
// ----------------------------------------------------------------------------
// Commands arrive as beats on the item channel (item_valid, item_ready).
// A set or init beat updates one voice in the cycle it is accepted, and
// item_ready stays high, so such beats can follow each other every cycle.
// A tick beat starts a frame: for each voice in turn the block advances its
// phase and reads the sine table, then runs the 4-bit digit-serial
// multiplier over the gain digits; a flush step adds the last voice, the
// sum goes to the sample register, and then the next beat is accepted. That
// multiplier sets the rate. item_ready is low while a frame is being computed.
// The sample leaves as a beat on the sample channel (sample_valid,
// sample_ready) from an output register. The next command is accepted while
// the sample waits; a following tick holds in its last cycle until the
// register is free, so a stalled receiver loses nothing.
// Reset clears every voice to zero gain, step and phase, which is silence,
// and leaves the block idle with the sample register empty.
// ----------------------------------------------------------------------------
`default_nettype none
`include "multi_voice_oscillator_mixer_macros.svh"

module multi_voice_oscillator_mixer
	import mvom_pkg::*;
(
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      item_valid,
	output logic                           item_ready,
	input  wire logic [CMD_W-1:0]          command,
	input  wire logic [VOICE_FIELD_W-1:0]  voice,
	input  wire logic [WAVE_W-1:0]         wave_type,
	input  wire logic [FREQ_W-1:0]         frequency_hz,
	input  wire logic [GAIN_W-1:0]         volume,
	output logic                           sample_valid,
	input  wire logic                      sample_ready,
	output logic signed [SAMPLE_W-1:0]     sample
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_PHASE = 3'd1;
	localparam logic [2:0] ST_MAC   = 3'd2;
	localparam logic [2:0] ST_FLUSH = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	localparam logic [VOICE_W-1:0]     VOICE_LAST = VOICE_W'(NUM_VOICES - 1);
	localparam logic [DIGIT_CNT_W-1:0] DIGIT_LAST = DIGIT_CNT_W'(GAIN_DIGITS - 1);

	logic [2:0]               state_q;
	logic [VOICE_W-1:0]       voice_cnt_q;
	logic [DIGIT_CNT_W-1:0]   digit_cnt_q;
	logic                     sample_valid_q;
	logic [SAMPLE_W-1:0]      sample_q;

	logic                       accept;
	logic                       voice_ok;
	logic                       out_load;
	bank_ctrl_t                 bank_ctrl;
	mac_ctrl_t                  mac_ctrl;
	voice_view_t                view;
	logic signed [SINE_W-1:0]   sine_level;
	logic signed [SAMPLE_W-1:0] mix_sample;

	assign item_ready = (state_q == ST_IDLE);
	assign accept     = item_valid && item_ready;
	assign voice_ok   = (int'(voice) < NUM_VOICES);
	assign out_load   = (state_q == ST_DONE) && (!sample_valid_q || sample_ready);

	always_comb begin
		bank_ctrl.set_en  = accept && (command == CMD_SET) && voice_ok;
		bank_ctrl.init_en = accept && (command == CMD_INIT) && voice_ok;
		bank_ctrl.advance = (state_q == ST_PHASE);
		bank_ctrl.sel     = (state_q == ST_IDLE) ? VOICE_W'(voice) : voice_cnt_q;
		bank_ctrl.wave    = wave_type;
		bank_ctrl.freq    = frequency_hz;
		bank_ctrl.gain    = volume;

		mac_ctrl.clear = accept && (command == CMD_TICK);
		mac_ctrl.load  = (state_q == ST_PHASE);
		mac_ctrl.shift = (state_q == ST_MAC);
		mac_ctrl.accum = (state_q == ST_PHASE) || (state_q == ST_FLUSH);
	end

	mvom_voice_bank u_bank (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (bank_ctrl),
		.view   (view)
	);

	mvom_sine_rom u_rom (
		.clk  (clk),
		.en   (state_q == ST_PHASE),
		.addr (view.phase[PHASE_W-1 -: SINE_ADDR_W]),
		.data (sine_level)
	);

	mvom_serial_mac u_mac (
		.clk        (clk),
		.ctrl       (mac_ctrl),
		.view       (view),
		.sine_level (sine_level),
		.sample     (mix_sample)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			voice_cnt_q <= '0;
			digit_cnt_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && (command == CMD_TICK)) begin
						voice_cnt_q <= '0;
						state_q     <= ST_PHASE;
					end
				end
				ST_PHASE: begin
					digit_cnt_q <= '0;
					state_q     <= ST_MAC;
				end
				ST_MAC: begin
					digit_cnt_q <= digit_cnt_q + DIGIT_CNT_W'(1);
					if (digit_cnt_q == DIGIT_LAST) begin
						if (voice_cnt_q == VOICE_LAST) begin
							state_q <= ST_FLUSH;
						end else begin
							voice_cnt_q <= voice_cnt_q + VOICE_W'(1);
							state_q     <= ST_PHASE;
						end
					end
				end
				ST_FLUSH: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_valid_q <= 1'b0;
		end else if (out_load) begin
			sample_valid_q <= 1'b1;
		end else if (sample_ready) begin
			sample_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			sample_q <= mix_sample;
		end
	end

	assign sample_valid = sample_valid_q;
	assign sample       = $signed(sample_q);

	`MVOM_NEVER(a_bank_op_clash, !$onehot0({bank_ctrl.set_en, bank_ctrl.init_en, bank_ctrl.advance}), "voice bank got more than one operation")
	`MVOM_ASSERT(a_tick_busy, (accept && (command == CMD_TICK)) |=> !item_ready, "tick beat did not start a frame")
	`MVOM_ASSERT(a_cmd_single, (accept && (command != CMD_TICK)) |=> item_ready, "set or init beat left the block busy")
	`MVOM_ASSERT(a_done_holds, ((state_q == ST_DONE) && sample_valid && !sample_ready) |=> (state_q == ST_DONE), "finished frame dropped while the receiver stalled")

endmodule

`default_nettype wire

[tb/tb_multi_voice_oscillator_mixer.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_multi_voice_oscillator_mixer
// Self-checking bench for the oscillator bank mixer.
// A queue of command beats feeds a clocked driver with random gaps. Every
// accepted beat updates a local copy of the voice bank, and each tick pushes
// the sample it must produce. A clocked monitor with random stalls, and one
// long hold-off that backs the block up, compares each sample beat in order.
// ----------------------------------------------------------------------------

module tb_multi_voice_oscillator_mixer;
	import mvom_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int RANDOM_BEATS = 1830;
	localparam int HOLD_CYCLES = 500;

	typedef struct {
		logic [CMD_W-1:0]         cmd;
		logic [VOICE_FIELD_W-1:0] vc;
		logic [WAVE_W-1:0]        wt;
		logic [FREQ_W-1:0]        fq;
		logic [GAIN_W-1:0]        vol;
		int                       gap;
	} cmd_beat_t;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        item_valid = 1'b0;
	logic                        item_ready;
	logic [CMD_W-1:0]            command = '0;
	logic [VOICE_FIELD_W-1:0]    voice = '0;
	logic [WAVE_W-1:0]           wave_type = '0;
	logic [FREQ_W-1:0]           frequency_hz = '0;
	logic [GAIN_W-1:0]           volume = '0;
	logic                        sample_valid;
	logic                        sample_ready = 1'b0;
	logic signed [SAMPLE_W-1:0]  sample;

	cmd_beat_t                   command_q[$];
	cmd_beat_t                   next_beat;
	logic signed [SAMPLE_W-1:0]  expected_samples[$];
	logic signed [SAMPLE_W-1:0]  want_sample;

	int                          sine_lut[SINE_ENTRIES];
	logic [PHASE_W-1:0]          osc_phase[NUM_VOICES];
	logic [PHASE_W-1:0]          osc_step[NUM_VOICES];
	logic [GAIN_W-1:0]           osc_gain[NUM_VOICES];
	logic [WAVE_W-1:0]           osc_wave[NUM_VOICES];

	int                          errors = 0;
	int                          rx_wait = 0;
	int                          samples_seen = 0;
	int                          hold_left = 0;
	logic                        hold_done = 1'b0;
	logic                        sender_idle = 1'b0;
	int                          beats_queued = 0;

	multi_voice_oscillator_mixer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.command      (command),
		.voice        (voice),
		.wave_type    (wave_type),
		.frequency_hz (frequency_hz),
		.volume       (volume),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Quarter-wave Taylor series in unsigned Q30, rounded to Q15.
	function automatic void build_sine_lut();
		longint unsigned m;
		longint unsigned x;
		longint unsigned x2;
		longint unsigned t;
		longint unsigned k;
		longint          acc;
		logic            neg;
		longint unsigned n;
		n = SINE_ENTRIES;
		for (int i = 0; i < SINE_ENTRIES; i++) begin
			m = 4 * longint'(i);
			neg = 1'b0;
			if (m >= 2 * n) begin
				neg = 1'b1;
				m = m - 2 * n;
			end
			if (m > n) begin
				m = 2 * n - m;
			end
			x = (longint'(HALF_PI_Q30) * m) / n;
			x2 = (x * x) >> 30;
			t = x;
			acc = longint'(x);
			for (k = 1; k <= 4; k++) begin
				t = ((t * x2) >> 30) / ((2 * k) * (2 * k + 1));
				if (k[0])
					acc = acc - longint'(t);
				else
					acc = acc + longint'(t);
			end
			if (acc < 0)
				acc = 0;
			acc = (acc + 16384) >>> 15;
			if (acc > 32767)
				acc = 32767;
			sine_lut[i] = neg ? -int'(acc) : int'(acc);
		end
	endfunction

	function automatic void advance_bank();
		longint               mix;
		longint               lvl;
		longint               s;
		logic [PHASE_W:0]     p;
		mix = 0;
		for (int v = 0; v < NUM_VOICES; v++) begin
			if (osc_gain[v] != '0) begin
				p = {1'b0, osc_phase[v]} + {1'b0, osc_step[v]};
				case (osc_wave[v])
					WAVE_SINE: begin
						osc_phase[v] = p[PHASE_W-1:0];
						lvl = sine_lut[(longint'(osc_phase[v]) * SINE_ENTRIES) >> PHASE_W];
					end
					WAVE_SQUARE: begin
						osc_phase[v] = p[PHASE_W] ? '0 : p[PHASE_W-1:0];
						lvl = osc_phase[v][PHASE_W-1] ? 32768 : 0;
					end
					WAVE_SAW: begin
						osc_phase[v] = p[PHASE_W] ? '0 : p[PHASE_W-1:0];
						lvl = longint'(osc_phase[v] >> SAW_SHIFT);
					end
					default: begin
						osc_phase[v] = p[PHASE_W-1:0];
						lvl = 0;
					end
				endcase
				mix = mix + lvl * longint'(osc_gain[v]);
			end
		end
		s = mix >>> FRAC_W;
		if (s > SAMPLE_MAX)
			s = SAMPLE_MAX;
		if (s < SAMPLE_MIN)
			s = SAMPLE_MIN;
		expected_samples.push_back(SAMPLE_W'(s));
	endfunction

	function automatic void apply_command(input logic [CMD_W-1:0] cmd,
		input logic [VOICE_FIELD_W-1:0] vc, input logic [WAVE_W-1:0] wt,
		input logic [FREQ_W-1:0] fq, input logic [GAIN_W-1:0] vol);
		longint f;
		if (cmd == CMD_TICK) begin
			advance_bank();
		end else if (cmd == CMD_SET && int'(vc) < NUM_VOICES) begin
			osc_gain[vc] = vol;
			osc_wave[vc] = wt;
			if (wt != WAVE_SILENT) begin
				f = (fq > FREQ_MAX) ? longint'(FREQ_MAX) : longint'(fq);
				osc_step[vc] = PHASE_W'((f * longint'(STEP_MUL)) >> STEP_SHIFT);
			end
		end else if (cmd == CMD_INIT && int'(vc) < NUM_VOICES) begin
			osc_phase[vc] = '0;
			osc_step[vc] = '0;
			osc_gain[vc] = '0;
			osc_wave[vc] = wt;
		end
	endfunction

	task automatic queue_beat(input logic [CMD_W-1:0] cmd, input logic [VOICE_FIELD_W-1:0] vc,
		input logic [WAVE_W-1:0] wt, input logic [FREQ_W-1:0] fq,
		input logic [GAIN_W-1:0] vol);
		cmd_beat_t b;
		b.cmd = cmd;
		b.vc = vc;
		b.wt = wt;
		b.fq = fq;
		b.vol = vol;
		b.gap = sender_idle ? $urandom_range(0, 7) : 0;
		command_q.push_back(b);
		beats_queued++;
	endtask

	function automatic logic [FREQ_W-1:0] pick_freq();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return FREQ_W'($urandom_range(0, 22050));
		else if (r < 90)
			return FREQ_W'($urandom_range(22051, 32767));
		case ($urandom_range(0, 3))
			0: return '0;
			1: return FREQ_W'(1);
			2: return FREQ_MAX;
			default: return '1;
		endcase
	endfunction

	function automatic logic [GAIN_W-1:0] pick_gain();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return '0;
		else if (r < 20)
			return '1;
		return GAIN_W'($urandom);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			command <= '0;
			voice <= '0;
			wave_type <= '0;
			frequency_hz <= '0;
			volume <= '0;
		end else begin
			if (item_valid && item_ready)
				apply_command(command, voice, wave_type, frequency_hz, volume);
			if (!item_valid || item_ready) begin
				if (command_q.size() != 0 && command_q[0].gap == 0) begin
					next_beat = command_q.pop_front();
					item_valid <= 1'b1;
					command <= next_beat.cmd;
					voice <= next_beat.vc;
					wave_type <= next_beat.wt;
					frequency_hz <= next_beat.fq;
					volume <= next_beat.vol;
				end else begin
					item_valid <= 1'b0;
					if (command_q.size() != 0)
						command_q[0].gap = command_q[0].gap - 1;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && samples_seen >= 30) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_ready <= 1'b0;
			samples_seen <= 0;
			rx_wait = 0;
		end else begin
			if (sample_valid && sample_ready) begin
				if (expected_samples.size() == 0) begin
					$error("unexpected sample beat: sample actual %0d", sample);
					errors++;
				end else begin
					want_sample = expected_samples.pop_front();
					if (sample !== want_sample) begin
						$error("sample mismatch: expected %0d, actual %0d",
							want_sample, sample);
						errors++;
					end
				end
				samples_seen <= samples_seen + 1;
				rx_wait = ((samples_seen % 128) < 80) ? $urandom_range(0, 7) : 0;
			end else if (rx_wait != 0) begin
				rx_wait--;
			end
			sample_ready <= (rx_wait == 0) && (hold_left == 0);
		end
	end

	initial begin
		int r;
		for (int v = 0; v < NUM_VOICES; v++) begin
			osc_phase[v] = '0;
			osc_step[v] = '0;
			osc_gain[v] = '0;
			osc_wave[v] = WAVE_SINE;
		end
		build_sine_lut();

		sender_idle = 1'b1;
		queue_beat(CMD_TICK, 4'd0, WAVE_SINE, '0, '0);
		queue_beat(CMD_SET, 4'd0, WAVE_SINE, FREQ_MAX, '1);
		queue_beat(CMD_TICK, '1, '1, '1, '1);
		queue_beat(CMD_TICK, 4'd0, WAVE_SINE, '0, '0);
		queue_beat(CMD_SET, 4'd1, WAVE_SQUARE, '1, '1);
		queue_beat(CMD_SET, 4'd2, WAVE_SAW, FREQ_W'(11025), GAIN_W'(32768));
		queue_beat(CMD_TICK, 4'd0, WAVE_SINE, '0, '0);
		queue_beat(CMD_TICK, 4'd0, WAVE_SINE, '0, '0);
		queue_beat(CMD_TICK, 4'd0, WAVE_SINE, '0, '0);
		queue_beat(CMD_SET, 4'd2, WAVE_SILENT, FREQ_W'(100), '1);
		queue_beat(CMD_TICK, 4'd0, WAVE_SINE, '0, '0);
		queue_beat(CMD_SET, 4'd2, WAVE_SAW, FREQ_W'(7000), '1);
		queue_beat(CMD_INIT, 4'd1, WAVE_SAW, '1, '1);
		queue_beat(CMD_UNUSED, '1, '1, '1, '1);
		queue_beat(CMD_TICK, 4'd0, WAVE_SINE, '0, '0);
		queue_beat(CMD_SET, '1, WAVE_SINE, '0, GAIN_W'(1));
		queue_beat(CMD_SET, 4'd3, WAVE_SQUARE, FREQ_W'(1), '0);
		queue_beat(CMD_SET, 4'd4, WAVE_SINE, FREQ_W'(3000), '1);
		queue_beat(CMD_TICK, 4'd0, WAVE_SINE, '0, '0);
		queue_beat(CMD_INIT, 4'd0, WAVE_SILENT, '0, '0);
		queue_beat(CMD_INIT, '1, WAVE_SINE, '0, '0);
		queue_beat(CMD_TICK, 4'd0, WAVE_SINE, '0, '0);

		for (int n = 0; beats_queued < RANDOM_BEATS + 22; n++) begin
			if (n % 100 == 0)
				sender_idle = ($urandom_range(0, 2) != 0);
			r = $urandom_range(0, 99);
			if (r < 45)
				queue_beat(CMD_TICK, VOICE_FIELD_W'($urandom), WAVE_W'($urandom),
					FREQ_W'($urandom), GAIN_W'($urandom));
			else if (r < 82)
				queue_beat(CMD_SET, VOICE_FIELD_W'($urandom), WAVE_W'($urandom),
					pick_freq(), pick_gain());
			else if (r < 93)
				queue_beat(CMD_INIT, VOICE_FIELD_W'($urandom), WAVE_W'($urandom),
					FREQ_W'($urandom), GAIN_W'($urandom));
			else
				queue_beat(CMD_UNUSED, VOICE_FIELD_W'($urandom), WAVE_W'($urandom),
					FREQ_W'($urandom), GAIN_W'($urandom));
		end

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (command_q.size() != 0 || item_valid)
			@(posedge clk);
		while (expected_samples.size() != 0)
			@(posedge clk);
		repeat (150) @(posedge clk);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#30_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule

[files.f]
+incdir+hdl
hdl/mvom_pkg.sv
hdl/mvom_sine_rom.sv
hdl/mvom_voice_bank.sv
hdl/mvom_serial_mac.sv
hdl/multi_voice_oscillator_mixer.sv
tb/tb_multi_voice_oscillator_mixer.sv
